>>> rtl/sfr_pkg.sv
package sfr_pkg;

	localparam int NUM_SENSORS = 3;

	localparam int BYTE_W = 8;
	localparam int DIST_W = 16;
	localparam int POS_W  = 3;

	localparam logic [POS_W-1:0] POS_HEADER = 3'd0;
	localparam logic [POS_W-1:0] POS_FIRST  = 3'd1;
	localparam logic [POS_W-1:0] POS_ID     = 3'd1;
	localparam logic [POS_W-1:0] POS_HIGH   = 3'd3;
	localparam logic [POS_W-1:0] POS_LOW    = 3'd4;
	localparam logic [POS_W-1:0] POS_CHECK  = 3'd5;
	localparam logic [POS_W-1:0] POS_LAST   = 3'd6;

	localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'hCC;
	localparam logic [BYTE_W-1:0] ID_BASE_RESET = 8'h11;

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER  = 1'b0,
		REG_ID_BASE = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_STORED  = 3'd1,
		ST_BADSUM  = 3'd2,
		ST_BADID   = 3'd3,
		ST_LINEERR = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	typedef struct packed {
		logic              clear;
		logic              wr;
		logic [BYTE_W-1:0] idx;
		logic [DIST_W-1:0] data;
	} tbl_cmd_t;

	typedef struct packed {
		logic [DIST_W-1:0] dist_a;
		logic [DIST_W-1:0] dist_b;
		logic [DIST_W-1:0] dist_c;
		logic              all_present;
	} dist_view_t;

endpackage

>>> rtl/sfr_if.sv
interface sfr_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;
	logic       line_error;

	modport source (output valid, action, rx_byte, line_error, input ready);
	modport sink (input valid, action, rx_byte, line_error, output ready);
endinterface

interface sfr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] dist_a;
	logic [15:0] dist_b;
	logic [15:0] dist_c;
	logic        all_present;

	modport source (output valid, status, dist_a, dist_b, dist_c, all_present, input ready);
	modport sink (input valid, status, dist_a, dist_b, dist_c, all_present, output ready);
endinterface

interface sfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/sensor_frame_receiver_top.sv
// channel  | dir | handshake     | payload
// item     | in  | valid / ready | action, rx_byte, line_error
// result   | out | valid / ready | status, dist_a, dist_b, dist_c, all_present
// cfg      | in  | valid / ready | index, data (0 header byte, 1 id base)
//
// one byte per cycle unless the result stalls; a result is registered as its item
// leaves the item register; the item and result registers are the two stages;
// the frame parser and the distance table update as an item leaves the item register
// a stalled result holds the result register; an empty item register takes one more
// arst_n clears frame state, the table, the valid flags and loads the register defaults
module sensor_frame_receiver_top
	import sfr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	sfr_in_if.sink    item,
	sfr_out_if.source result,
	sfr_cfg_if.sink   cfg
);

	logic              valid_s1;
	logic              action_s1;
	logic [BYTE_W-1:0] rx_s1;
	logic              lerr_s1;
	logic              valid_s2;
	status_t           status_s2;
	dist_view_t        view_s2;
	logic [BYTE_W-1:0] header_q;
	logic [BYTE_W-1:0] base_q;
	logic              advance;
	status_t           status;
	tbl_cmd_t          cmd;
	dist_view_t        view;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			base_q   <= ID_BASE_RESET;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_HEADER:  header_q <= cfg.data;
				REG_ID_BASE: base_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_s1 <= item.action;
			rx_s1     <= item.rx_byte;
			lerr_s1   <= item.line_error;
		end
	end

	sfr_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.action      (action_s1),
		.rx_byte     (rx_s1),
		.line_error  (lerr_s1),
		.header_byte (header_q),
		.id_base     (base_q),
		.status      (status),
		.cmd         (cmd)
	);

	sfr_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cmd     (cmd),
		.view    (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status;
			view_s2   <= view;
		end
	end

	assign result.valid       = valid_s2;
	assign result.status      = status_s2;
	assign result.dist_a      = view_s2.dist_a;
	assign result.dist_b      = view_s2.dist_b;
	assign result.dist_c      = view_s2.dist_c;
	assign result.all_present = view_s2.all_present;

endmodule

>>> rtl/sfr_parser.sv
module sfr_parser
	import sfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              action,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              line_error,
	input  logic [BYTE_W-1:0] header_byte,
	input  logic [BYTE_W-1:0] id_base,
	output status_t           status,
	output tbl_cmd_t          cmd
);

	logic [POS_W-1:0]  pos_q, pos_n;
	logic [BYTE_W-1:0] sum_q, sum_n;
	logic [BYTE_W-1:0] id_q, id_n;
	logic [BYTE_W-1:0] high_q, high_n;
	logic [BYTE_W-1:0] low_q, low_n;
	logic [BYTE_W-1:0] chk_q, chk_n;
	logic [BYTE_W-1:0] sum_add;
	logic [BYTE_W-1:0] idx;

	assign sum_add = sum_q + rx_byte;
	assign idx     = id_q - id_base;

	always_comb begin
		pos_n  = pos_q;
		sum_n  = sum_q;
		id_n   = id_q;
		high_n = high_q;
		low_n  = low_q;
		chk_n  = chk_q;
		status = ST_IDLE;
		cmd    = '0;
		cmd.idx  = idx;
		cmd.data = {high_q, low_q};
		if (action) begin
			cmd.clear = 1'b1;
			status    = ST_CLEARED;
		end else if (line_error) begin
			pos_n  = POS_HEADER;
			status = ST_LINEERR;
		end else if (pos_q == POS_HEADER) begin
			if (rx_byte == header_byte) begin
				sum_n = rx_byte;
				pos_n = POS_FIRST;
			end
		end else begin
			case (pos_q)
				POS_ID:    id_n   = rx_byte;
				POS_HIGH:  high_n = rx_byte;
				POS_LOW:   low_n  = rx_byte;
				POS_CHECK: chk_n  = rx_byte;
				default: ;
			endcase
			if (pos_q != POS_CHECK) begin
				sum_n = sum_add;
			end
			pos_n = pos_q + POS_FIRST;
			if (pos_q == POS_LAST) begin
				pos_n = POS_HEADER;
				if (sum_add == chk_q) begin
					if (idx < BYTE_W'(NUM_SENSORS)) begin
						cmd.wr = 1'b1;
						status = ST_STORED;
					end else begin
						status = ST_BADID;
					end
				end else begin
					status = ST_BADSUM;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_HEADER;
			sum_q  <= '0;
			id_q   <= '0;
			high_q <= '0;
			low_q  <= '0;
			chk_q  <= '0;
		end else if (advance) begin
			pos_q  <= pos_n;
			sum_q  <= sum_n;
			id_q   <= id_n;
			high_q <= high_n;
			low_q  <= low_n;
			chk_q  <= chk_n;
		end
	end

endmodule

>>> rtl/sfr_table.sv
module sfr_table
	import sfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  tbl_cmd_t   cmd,
	output dist_view_t view
);

	logic [DIST_W-1:0] tbl_q [NUM_SENSORS];
	logic [DIST_W-1:0] tbl_n [NUM_SENSORS];
	logic [DIST_W-1:0] shown [3];

	always_comb begin
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (cmd.clear) begin
				tbl_n[i] = '0;
			end else if (cmd.wr && cmd.idx == BYTE_W'(i)) begin
				tbl_n[i] = cmd.data;
			end else begin
				tbl_n[i] = tbl_q[i];
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_show
		if (k < NUM_SENSORS) begin : g_have
			assign shown[k] = tbl_n[k];
		end else begin : g_none
			assign shown[k] = '0;
		end
	end

	assign view.dist_a      = shown[0];
	assign view.dist_b      = shown[1];
	assign view.dist_c      = shown[2];
	assign view.all_present = (shown[0] != '0) && (shown[1] != '0) && (shown[2] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				tbl_q[i] <= '0;
			end
		end else if (advance) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				tbl_q[i] <= tbl_n[i];
			end
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import sfr_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int PHASE_ITEMS = 120;
	localparam int MAX_REPORTS = 50;

	typedef struct packed {
		status_t           status;
		logic [DIST_W-1:0] dist_a;
		logic [DIST_W-1:0] dist_b;
		logic [DIST_W-1:0] dist_c;
		logic              all_present;
	} sensor_view_t;

	typedef struct packed {
		logic              action;
		logic [BYTE_W-1:0] rx_byte;
		logic              line_error;
		logic              pinned;
		sensor_view_t      view;
	} rx_row_t;

	localparam sensor_view_t IDLE_VIEW = '{ST_IDLE, 16'h0, 16'h0, 16'h0, 1'b0};

	localparam rx_row_t DIRECTED_ROWS [0:25] = '{
		'{1'b1, 8'h00, 1'b0, 1'b1, '{ST_CLEARED, 16'h0, 16'h0, 16'h0, 1'b0}},
		'{1'b0, 8'hCC, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'hFF, 1'b1, 1'b1, '{ST_LINEERR, 16'h0, 16'h0, 16'h0, 1'b0}},
		'{1'b0, 8'h00, 1'b0, 1'b1, IDLE_VIEW},
		// good frame, sensor 0
		'{1'b0, 8'hCC, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'h11, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'h00, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'h12, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'h34, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'h23, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'h00, 1'b0, 1'b1, '{ST_STORED, 16'h1234, 16'h0, 16'h0, 1'b0}},
		// clear in the middle of a frame for sensor 2
		'{1'b0, 8'hCC, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'h13, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b1, 8'hFF, 1'b1, 1'b1, '{ST_CLEARED, 16'h0, 16'h0, 16'h0, 1'b0}},
		'{1'b0, 8'hFF, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'hFF, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'hFF, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'hDB, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'hFF, 1'b0, 1'b1, '{ST_STORED, 16'h0, 16'h0, 16'hFFFF, 1'b0}},
		// id below the base wraps out of range
		'{1'b0, 8'hCC, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'h10, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'h00, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'h00, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'h01, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'hDD, 1'b0, 1'b0, IDLE_VIEW},
		'{1'b0, 8'h00, 1'b0, 1'b1, '{ST_BADID, 16'h0, 16'h0, 16'hFFFF, 1'b0}}
	};

	logic clk;
	logic arst_n;

	sfr_in_if  item_bus ();
	sfr_out_if result_bus ();
	sfr_cfg_if cfg_bus ();

	sensor_frame_receiver_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// frame parser shadow state
	logic [BYTE_W-1:0] hdr_byte  = HEADER_RESET;
	logic [BYTE_W-1:0] id_base   = ID_BASE_RESET;
	logic [POS_W-1:0]  frm_pos   = POS_HEADER;
	logic [BYTE_W-1:0] frm_sum   = '0;
	logic [BYTE_W-1:0] frm_id    = '0;
	logic [BYTE_W-1:0] frm_high  = '0;
	logic [BYTE_W-1:0] frm_low   = '0;
	logic [BYTE_W-1:0] frm_check = '0;
	logic [DIST_W-1:0] dist_tbl [NUM_SENSORS] = '{default: '0};

	rx_row_t      inflight_rows[$];
	sensor_view_t pending_views[$];
	int unsigned  mismatches = 0;
	int unsigned  cycle_count = 0;
	int unsigned  stall_left = 0;
	bit           quiet = 1'b0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [DIST_W-1:0] table_word(int i);
		return (i < NUM_SENSORS) ? dist_tbl[i] : '0;
	endfunction

	function automatic sensor_view_t parse_byte(logic act, logic [BYTE_W-1:0] b, logic lerr);
		sensor_view_t      v;
		logic [BYTE_W-1:0] slot;
		v.status = ST_IDLE;
		if (act) begin
			for (int i = 0; i < NUM_SENSORS; i++)
				dist_tbl[i] = '0;
			v.status = ST_CLEARED;
		end else if (lerr) begin
			frm_pos = POS_HEADER;
			v.status = ST_LINEERR;
		end else if (frm_pos == POS_HEADER) begin
			if (b == hdr_byte) begin
				frm_sum = b;
				frm_pos = POS_FIRST;
			end
		end else begin
			case (frm_pos)
				POS_ID:    frm_id = b;
				POS_HIGH:  frm_high = b;
				POS_LOW:   frm_low = b;
				POS_CHECK: frm_check = b;
				default: ;
			endcase
			if (frm_pos != POS_CHECK)
				frm_sum = frm_sum + b;
			if (frm_pos == POS_LAST) begin
				frm_pos = POS_HEADER;
				slot = frm_id - id_base;
				if (frm_sum != frm_check) begin
					v.status = ST_BADSUM;
				end else if (slot < NUM_SENSORS) begin
					dist_tbl[slot] = {frm_high, frm_low};
					v.status = ST_STORED;
				end else begin
					v.status = ST_BADID;
				end
			end else begin
				frm_pos = frm_pos + 3'd1;
			end
		end
		v.dist_a = table_word(0);
		v.dist_b = table_word(1);
		v.dist_c = table_word(2);
		v.all_present = (v.dist_a != 0) && (v.dist_b != 0) && (v.dist_c != 0);
		return v;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (mismatches < MAX_REPORTS)
			$display("mismatch %s: got %0h want %0h at %0t ns", what, got, want, $time);
		mismatches++;
	endtask

	always @(posedge clk) begin : watch
		rx_row_t      row;
		sensor_view_t want;
		if (cfg_bus.valid && cfg_bus.ready) begin
			case (cfg_reg_t'(cfg_bus.index))
				REG_HEADER:  hdr_byte = cfg_bus.data;
				REG_ID_BASE: id_base = cfg_bus.data;
				default: ;
			endcase
		end
		if (item_bus.valid && item_bus.ready) begin
			row = inflight_rows.pop_front();
			want = parse_byte(item_bus.action, item_bus.rx_byte, item_bus.line_error);
			pending_views.push_back(row.pinned ? row.view : want);
		end
		if (result_bus.valid && result_bus.ready) begin
			if (pending_views.size() == 0) begin
				report_mismatch("result with nothing pending", result_bus.status, 0);
			end else begin
				want = pending_views.pop_front();
				if (result_bus.status !== want.status)
					report_mismatch("status", result_bus.status, want.status);
				if (result_bus.dist_a !== want.dist_a)
					report_mismatch("dist_a", result_bus.dist_a, want.dist_a);
				if (result_bus.dist_b !== want.dist_b)
					report_mismatch("dist_b", result_bus.dist_b, want.dist_b);
				if (result_bus.dist_c !== want.dist_c)
					report_mismatch("dist_c", result_bus.dist_c, want.dist_c);
				if (result_bus.all_present !== want.all_present)
					report_mismatch("all_present", result_bus.all_present, want.all_present);
			end
		end
	end

	// result side backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else if (stall_left != 0) begin
			result_bus.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			result_bus.ready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			result_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_item(rx_row_t row);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_bus.valid      <= 1'b1;
		item_bus.action     <= row.action;
		item_bus.rx_byte    <= row.rx_byte;
		item_bus.line_error <= row.line_error;
		inflight_rows.push_back(row);
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
	endtask

	task automatic drain();
		item_bus.valid <= 1'b0;
		while (inflight_rows.size() != 0 || pending_views.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [BYTE_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic send_frame(logic [BYTE_W-1:0] hdr, logic [BYTE_W-1:0] base);
		logic [BYTE_W-1:0] fb [7];
		logic [DIST_W-1:0] range_val;
		int                cut;
		case ($urandom_range(0, 9))
			0: range_val = '0;
			1: range_val = '1;
			default: range_val = DIST_W'($urandom_range(0, 65535));
		endcase
		fb[0] = hdr;
		fb[1] = ($urandom_range(0, 6) != 0) ? BYTE_W'(base + $urandom_range(0, 2))
			: BYTE_W'($urandom_range(0, 255));
		fb[2] = BYTE_W'($urandom_range(0, 255));
		fb[3] = range_val[15:8];
		fb[4] = range_val[7:0];
		fb[6] = BYTE_W'($urandom_range(0, 255));
		fb[5] = fb[0] + fb[1] + fb[2] + fb[3] + fb[4] + fb[6];
		if ($urandom_range(0, 6) == 0)
			fb[5] = fb[5] ^ BYTE_W'($urandom_range(1, 255));
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 7;
		for (int k = 0; k < 7; k++) begin
			if (k == cut) begin
				send_item('{1'b0, BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0, IDLE_VIEW});
				break;
			end
			if ($urandom_range(0, 39) == 0)
				send_item('{1'b1, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'b0, IDLE_VIEW});
			send_item('{1'b0, fb[k], 1'b0, 1'b0, IDLE_VIEW});
		end
	endtask

	task automatic run_random(logic [BYTE_W-1:0] hdr, logic [BYTE_W-1:0] base, int n);
		int sent;
		int pick;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(hdr, base);
				sent += 7;
			end else if (pick < 85) begin
				// noise between frames, mostly ignored
				send_item('{1'b0, BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0, IDLE_VIEW});
				sent++;
			end else if (pick < 93) begin
				send_item('{1'b0, BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0, IDLE_VIEW});
				sent++;
			end else begin
				send_item('{1'b1, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'b0, IDLE_VIEW});
				sent++;
			end
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] hdr_set  [5];
		logic [BYTE_W-1:0] base_set [5];
		hdr_set  = '{8'h00, 8'hFF, 8'hFF, 8'h00, HEADER_RESET};
		base_set = '{8'h00, 8'hFF, 8'hFE, 8'h00, ID_BASE_RESET};
		hdr_set[3]  = BYTE_W'($urandom_range(0, 255));
		base_set[3] = BYTE_W'($urandom_range(0, 255));

		arst_n              = 1'b0;
		item_bus.valid      = 1'b0;
		item_bus.action     = 1'b0;
		item_bus.rx_byte    = '0;
		item_bus.line_error = 1'b0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.index       = REG_HEADER;
		cfg_bus.data        = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_ROWS[i])
			send_item(DIRECTED_ROWS[i]);

		for (int p = 0; p < 5; p++) begin
			drain();
			write_reg(REG_HEADER, hdr_set[p]);
			write_reg(REG_ID_BASE, base_set[p]);
			if (p == 4)
				quiet = 1'b1;
			run_random(hdr_set[p], base_set[p], PHASE_ITEMS);
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
